[design/sha1bsh_pkg.sv]
// Package with the types and fixed constants of the SHA-1 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1bsh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned ChainWords = 5;
  localparam int unsigned BlockBits  = 512;
  localparam int unsigned PosW       = 6;
  localparam int unsigned CountW     = 61;
  localparam int unsigned RoundW     = 7;

  localparam word_t HInit [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam byte_t PadByte = 8'h80;
  localparam byte_t ZeroByte = 8'h00;

  localparam logic [PosW-1:0]   LenPos    = 6'd56;
  localparam logic [PosW-1:0]   LastPos   = 6'd63;
  localparam logic [RoundW-1:0] Round20   = 7'd20;
  localparam logic [RoundW-1:0] Round40   = 7'd40;
  localparam logic [RoundW-1:0] Round60   = 7'd60;
  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [2:0]        LastIdx   = 3'd4;

endpackage

`default_nettype wire

[design/sha1_byte_stream_hash.sv]
// SHA-1 hasher over a byte stream: byte loading, padding, round unit and digest output.
`timescale 1ns / 1ps
`default_nettype none

// The block hashes a byte stream with SHA-1 and returns the 160-bit digest as five
// requests on the output channel, h0 first, each word big-endian, the fifth marked by
// out_tlast. An input request carries one byte when in_tuser is high; in_tlast ends the
// message, after the byte if one is present, and a request with in_tlast alone ends the
// message as it stands (an empty message if nothing came before). A request with neither
// flag is taken and has no effect. Message bytes are taken one per cycle until a byte
// fills a 64-byte block; that byte then holds the input off while a single round unit
// runs the 80 rounds, one per cycle, and adds the result into the chaining words. At the
// end of a message the pad bytes (the 0x80 byte, zeros and the eight length bytes) are
// loaded one per cycle through the same byte path, except for a step that loads nothing
// on reaching the length field and one or two compressions, after which the digest is
// handed over. When the message leaves eight or fewer bytes free in its last block, a
// second block of padding has to be compressed. The digest sits in its own output
// register, so the next message is taken while it drains; only the hand-over of a second
// digest waits for the first to be fully taken. The bit count wraps modulo 2^64.
module sha1_byte_stream_hash (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] byte_valid
  input  wire         in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // taking input requests
  localparam logic [2:0] S_ROUND = 3'd1;  // one compression round per cycle
  localparam logic [2:0] S_ADD   = 3'd2;  // add working words into the chain
  localparam logic [2:0] S_PAD80 = 3'd3;  // load the 0x80 pad byte
  localparam logic [2:0] S_ZERO  = 3'd4;  // load zero fill up to the length field
  localparam logic [2:0] S_LEN   = 3'd5;  // load the eight length bytes
  localparam logic [2:0] S_DONE  = 3'd6;  // hand the digest to the output register

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;       // state to resume once a compression ends

  // Byte position within the current block and count of message bytes.
  logic [sha1bsh_pkg::PosW-1:0]   pos_r, pos_nxt;
  logic [sha1bsh_pkg::CountW-1:0] cnt_r, cnt_nxt;

  // The block is loaded as a shift line: bytes enter at the bottom, so the first byte
  // of the block ends up in the top bits. During the rounds the same line shifts by a
  // word per cycle: the top word is the schedule word of the current round and the new
  // schedule word enters at the bottom.
  logic [sha1bsh_pkg::BlockBits-1:0] blk_r, blk_nxt;

  sha1bsh_pkg::word_t chain_r [sha1bsh_pkg::ChainWords];
  sha1bsh_pkg::word_t chain_nxt [sha1bsh_pkg::ChainWords];
  sha1bsh_pkg::word_t a_r, b_r, c_r, d_r, e_r;
  sha1bsh_pkg::word_t a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [sha1bsh_pkg::RoundW-1:0] rnd_r, rnd_nxt;

  // Output register: the five digest words, the current one in the top bits.
  logic [32*sha1bsh_pkg::ChainWords-1:0] obuf_r, obuf_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [2:0] oidx_r, oidx_nxt;

  logic                in_acc;
  logic                out_acc;
  logic                ins_en;
  sha1bsh_pkg::byte_t  ins_byte;
  logic [63:0]         len_w;
  sha1bsh_pkg::byte_t  len_byte;
  sha1bsh_pkg::word_t  w_cur, w_new, w_mix, f_w, k_w, t_w;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_acc    = ovalid_r && out_tready;
  assign out_tdata  = obuf_r[32*sha1bsh_pkg::ChainWords-1 -: 32];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == sha1bsh_pkg::LastIdx);

  // Length field: the message bit count, sent most significant byte first.
  assign len_w    = {cnt_r, 3'b000};
  assign len_byte = len_w[{~pos_r[2:0], 3'b000} +: 8];

  // Round unit with its schedule taps at words 0, 2, 8 and 13 of the line.
  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[511:480] ^ blk_r[447:416] ^ blk_r[255:224] ^ blk_r[95:64];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd_r < sha1bsh_pkg::Round20) begin
      f_w = (b_r & c_r) | (~b_r & d_r);
      k_w = sha1bsh_pkg::K0;
    end else if (rnd_r < sha1bsh_pkg::Round40) begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = sha1bsh_pkg::K1;
    end else if (rnd_r < sha1bsh_pkg::Round60) begin
      f_w = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_w = sha1bsh_pkg::K2;
    end else begin
      f_w = b_r ^ c_r ^ d_r;
      k_w = sha1bsh_pkg::K3;
    end
  end

  assign t_w = {a_r[26:0], a_r[31:27]} + f_w + e_r + k_w + w_cur;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    blk_nxt    = blk_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    e_nxt      = e_r;
    rnd_nxt    = rnd_r;
    chain_nxt  = chain_r;
    obuf_nxt   = obuf_r;
    ovalid_nxt = ovalid_r;
    oidx_nxt   = oidx_r;
    ins_en     = 1'b0;
    ins_byte   = sha1bsh_pkg::ZeroByte;

    // Drain the output register one word per request.
    if (out_acc) begin
      obuf_nxt = {obuf_r[32*sha1bsh_pkg::ChainWords-33:0], 32'h0};
      if (oidx_r == sha1bsh_pkg::LastIdx) begin
        ovalid_nxt = 1'b0;
      end else begin
        oidx_nxt = oidx_r + 3'd1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tlast ? S_PAD80 : S_IDLE;
          ret_nxt   = in_tlast ? S_PAD80 : S_IDLE;
          if (in_tuser) begin
            ins_en   = 1'b1;
            ins_byte = in_tdata;
            cnt_nxt  = cnt_r + {{(sha1bsh_pkg::CountW-1){1'b0}}, 1'b1};
          end
        end
      end
      S_ROUND: begin
        a_nxt   = t_w;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        blk_nxt = {blk_r[479:0], w_new};
        rnd_nxt = rnd_r + {{(sha1bsh_pkg::RoundW-1){1'b0}}, 1'b1};
        if (rnd_r == sha1bsh_pkg::LastRound) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        state_nxt    = ret_r;
      end
      S_PAD80: begin
        ins_en    = 1'b1;
        ins_byte  = sha1bsh_pkg::PadByte;
        state_nxt = S_ZERO;
        ret_nxt   = S_ZERO;
      end
      S_ZERO: begin
        if (pos_r == sha1bsh_pkg::LenPos) begin
          state_nxt = S_LEN;
        end else begin
          ins_en  = 1'b1;
          ret_nxt = S_ZERO;
        end
      end
      S_LEN: begin
        ins_en   = 1'b1;
        ins_byte = len_byte;
        ret_nxt  = S_DONE;
      end
      S_DONE: begin
        // Wait until the previous digest has been fully taken.
        if (!ovalid_r) begin
          obuf_nxt   = {chain_r[0], chain_r[1], chain_r[2], chain_r[3], chain_r[4]};
          ovalid_nxt = 1'b1;
          oidx_nxt   = 3'd0;
          chain_nxt  = sha1bsh_pkg::HInit;
          cnt_nxt    = '0;
          pos_nxt    = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Shared byte path; the byte that completes a block starts a compression.
    if (ins_en) begin
      blk_nxt = {blk_r[sha1bsh_pkg::BlockBits-9:0], ins_byte};
      pos_nxt = pos_r + {{(sha1bsh_pkg::PosW-1){1'b0}}, 1'b1};
      if (pos_r == sha1bsh_pkg::LastPos) begin
        state_nxt = S_ROUND;
        rnd_nxt   = '0;
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        e_nxt     = chain_r[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      pos_r    <= '0;
      cnt_r    <= '0;
      rnd_r    <= '0;
      chain_r  <= sha1bsh_pkg::HInit;
      ovalid_r <= 1'b0;
      oidx_r   <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      rnd_r    <= rnd_nxt;
      chain_r  <= chain_nxt;
      ovalid_r <= ovalid_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
    obuf_r <= obuf_nxt;
  end

endmodule

`default_nettype wire
